[rtl/rdg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rdg_pkg
// Shared types, codes and helpers of the repetition displacement generator.
// ----------------------------------------------------------------------------
package rdg_pkg;

    localparam int COORD_BITS = 48;
    localparam int COUNT_BITS = 16;
    localparam int DELTA_BITS = 32;
    localparam int GRID_BITS  = 16;
    localparam int MODE_BITS  = 4;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [MODE_BITS-1:0] MODE_REUSE     = 4'd0;
    localparam logic [MODE_BITS-1:0] MODE_REG_2D    = 4'd1;
    localparam logic [MODE_BITS-1:0] MODE_HREG      = 4'd2;
    localparam logic [MODE_BITS-1:0] MODE_VREG      = 4'd3;
    localparam logic [MODE_BITS-1:0] MODE_HIRR      = 4'd4;
    localparam logic [MODE_BITS-1:0] MODE_HIRR_GRID = 4'd5;
    localparam logic [MODE_BITS-1:0] MODE_VIRR      = 4'd6;
    localparam logic [MODE_BITS-1:0] MODE_VIRR_GRID = 4'd7;
    localparam logic [MODE_BITS-1:0] MODE_DIAG_2D   = 4'd8;
    localparam logic [MODE_BITS-1:0] MODE_DIAG_1D   = 4'd9;
    localparam logic [MODE_BITS-1:0] MODE_ARB       = 4'd10;
    localparam logic [MODE_BITS-1:0] MODE_ARB_GRID  = 4'd11;

    localparam logic [CFG_INDEX_BITS-1:0] REG_REP_MODE   = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT_A    = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT_B    = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_SCALE = 8'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_A_X   = 8'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_A_Y   = 8'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_B_X   = 8'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_B_Y   = 8'd7;

    localparam logic [COUNT_BITS-1:0] COUNT_TOP = {{(COUNT_BITS-1){1'b1}}, 1'b0} - 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DELTA_BITS-1:0] delta_t;
    typedef logic [COUNT_BITS-1:0]        count_t;

    typedef struct packed {
        logic [MODE_BITS-1:0] rep_mode;
        count_t               count_a;
        count_t               count_b;
        logic [GRID_BITS-1:0] grid_scale;
        delta_t               step_a_x;
        delta_t               step_a_y;
        delta_t               step_b_x;
        delta_t               step_b_y;
    } cfg_t;

    typedef struct packed {
        logic   start;
        logic   mode_ok;
        logic   two_d;
        count_t inner_max;
        count_t outer_max;
        coord_t inner_dx;
        coord_t inner_dy;
        coord_t outer_dx;
        coord_t outer_dy;
    } step_req_t;

    function automatic coord_t to_coord(input delta_t v);
        return coord_t'(v);
    endfunction

endpackage
`default_nettype wire

[rtl/rdg_step_decode.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rdg_step_decode
// Decodes the mode into point counts and the inner and outer deltas of one
// word, including the grid multiply of the grid variants.
// ----------------------------------------------------------------------------
module rdg_step_decode (
    input  wire rdg_pkg::cfg_t   cfg,
    input  wire logic            req_type,
    input  wire rdg_pkg::delta_t elem_x,
    input  wire rdg_pkg::delta_t elem_y,
    output rdg_pkg::step_req_t   req
);

    rdg_pkg::count_t ca;
    rdg_pkg::count_t cb;
    logic signed [rdg_pkg::DELTA_BITS+rdg_pkg::GRID_BITS:0] gx_prod;
    logic signed [rdg_pkg::DELTA_BITS+rdg_pkg::GRID_BITS:0] gy_prod;
    rdg_pkg::coord_t ex;
    rdg_pkg::coord_t ey;
    rdg_pkg::coord_t gx;
    rdg_pkg::coord_t gy;

    assign ca = ((cfg.count_a > rdg_pkg::COUNT_TOP) ? rdg_pkg::COUNT_TOP : cfg.count_a) + 1'b1;
    assign cb = ((cfg.count_b > rdg_pkg::COUNT_TOP) ? rdg_pkg::COUNT_TOP : cfg.count_b) + 1'b1;

    assign gx_prod = elem_x * $signed({1'b0, cfg.grid_scale});
    assign gy_prod = elem_y * $signed({1'b0, cfg.grid_scale});

    assign ex = rdg_pkg::to_coord(elem_x);
    assign ey = rdg_pkg::to_coord(elem_y);
    assign gx = rdg_pkg::coord_t'(gx_prod);
    assign gy = rdg_pkg::coord_t'(gy_prod);

    always_comb begin
        req = '0;
        req.start   = !req_type;
        req.mode_ok = (cfg.rep_mode >= rdg_pkg::MODE_REG_2D)
                   && (cfg.rep_mode <= rdg_pkg::MODE_ARB_GRID);
        req.two_d   = (cfg.rep_mode == rdg_pkg::MODE_REG_2D)
                   || (cfg.rep_mode == rdg_pkg::MODE_DIAG_2D);
        req.inner_max = ca;
        case (cfg.rep_mode)
            rdg_pkg::MODE_REG_2D: begin
                req.outer_max = cb;
                req.inner_dx  = rdg_pkg::to_coord(cfg.step_a_x);
                req.outer_dy  = rdg_pkg::to_coord(cfg.step_b_y);
            end
            rdg_pkg::MODE_HREG: begin
                req.inner_dx = rdg_pkg::to_coord(cfg.step_a_x);
            end
            rdg_pkg::MODE_VREG: begin
                req.inner_max = cb;
                req.inner_dy  = rdg_pkg::to_coord(cfg.step_a_y);
            end
            rdg_pkg::MODE_HIRR: begin
                req.inner_dx = ex;
            end
            rdg_pkg::MODE_HIRR_GRID: begin
                req.inner_dx = gx;
            end
            rdg_pkg::MODE_VIRR: begin
                req.inner_max = cb;
                req.inner_dy  = ex;
            end
            rdg_pkg::MODE_VIRR_GRID: begin
                req.inner_max = cb;
                req.inner_dy  = gx;
            end
            rdg_pkg::MODE_DIAG_2D: begin
                req.inner_max = cb;
                req.outer_max = ca;
                req.inner_dx  = rdg_pkg::to_coord(cfg.step_b_x);
                req.inner_dy  = rdg_pkg::to_coord(cfg.step_b_y);
                req.outer_dx  = rdg_pkg::to_coord(cfg.step_a_x);
                req.outer_dy  = rdg_pkg::to_coord(cfg.step_a_y);
            end
            rdg_pkg::MODE_DIAG_1D: begin
                req.inner_dx = rdg_pkg::to_coord(cfg.step_a_x);
                req.inner_dy = rdg_pkg::to_coord(cfg.step_a_y);
            end
            rdg_pkg::MODE_ARB: begin
                req.inner_dx = ex;
                req.inner_dy = ey;
            end
            default: begin
                req.inner_dx = gx;
                req.inner_dy = gy;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/repetition_displacement_generator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// repetition_displacement_generator_core
// Expands a layout repetition into displacement points with a running
// bounding box, one point per input word.
// ----------------------------------------------------------------------------
//  channel  ports                                   direction
//  s_       s_valid s_ready s_req_type s_elem_x/y  word in
//  m_       m_valid m_ready m_disp_* m_box_* flags  word out
//  cfg_     cfg_valid cfg_ready cfg_index cfg_data  register write
//
//  One word per cycle sustained while the result is not stalled.
//  The first stage decodes the mode and does the grid multiply; the second
//  adds into the accumulators and updates the box, which are the result.
//  A stalled result holds both stages; no clearing pass after reset.
// ----------------------------------------------------------------------------
module repetition_displacement_generator_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [rdg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [rdg_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_req_type,
    input  wire rdg_pkg::delta_t                      s_elem_x,
    input  wire rdg_pkg::delta_t                      s_elem_y,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output rdg_pkg::coord_t                           m_disp_x,
    output rdg_pkg::coord_t                           m_disp_y,
    output rdg_pkg::coord_t                           m_box_left,
    output rdg_pkg::coord_t                           m_box_bottom,
    output rdg_pkg::coord_t                           m_box_right,
    output rdg_pkg::coord_t                           m_box_top,
    output logic                                      m_is_last,
    output logic                                      m_error_flag
);

    rdg_pkg::cfg_t      cfg_reg;
    rdg_pkg::step_req_t dec_req;
    rdg_pkg::step_req_t a_req_reg;
    logic               a_valid_reg;
    logic               m_valid_reg;
    logic               out_adv;

    rdg_pkg::coord_t point_x_reg, point_x_next;
    rdg_pkg::coord_t point_y_reg, point_y_next;
    rdg_pkg::coord_t row_x_reg, row_x_next;
    rdg_pkg::coord_t row_y_reg, row_y_next;
    rdg_pkg::coord_t left_reg, left_next;
    rdg_pkg::coord_t bottom_reg, bottom_next;
    rdg_pkg::coord_t right_reg, right_next;
    rdg_pkg::coord_t top_reg, top_next;
    rdg_pkg::count_t inner_reg, inner_next;
    rdg_pkg::count_t outer_reg, outer_next;
    logic            finished_reg, finished_next;
    logic            last_reg, last_next;
    logic            err_reg, err_next;

    rdg_step_decode u_decode (
        .cfg      (cfg_reg),
        .req_type (s_req_type),
        .elem_x   (s_elem_x),
        .elem_y   (s_elem_y),
        .req      (dec_req)
    );

    assign cfg_ready = 1'b1;
    assign out_adv   = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !a_valid_reg || out_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rep_mode   <= rdg_pkg::MODE_REG_2D;
            cfg_reg.count_a    <= '0;
            cfg_reg.count_b    <= '0;
            cfg_reg.grid_scale <= rdg_pkg::GRID_BITS'(1);
            cfg_reg.step_a_x   <= '0;
            cfg_reg.step_a_y   <= '0;
            cfg_reg.step_b_x   <= '0;
            cfg_reg.step_b_y   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                rdg_pkg::REG_REP_MODE:   cfg_reg.rep_mode <= cfg_data[rdg_pkg::MODE_BITS-1:0];
                rdg_pkg::REG_COUNT_A:    cfg_reg.count_a  <= cfg_data[rdg_pkg::COUNT_BITS-1:0];
                rdg_pkg::REG_COUNT_B:    cfg_reg.count_b  <= cfg_data[rdg_pkg::COUNT_BITS-1:0];
                rdg_pkg::REG_GRID_SCALE: begin
                    cfg_reg.grid_scale <= cfg_data[rdg_pkg::GRID_BITS-1:0];
                end
                rdg_pkg::REG_STEP_A_X:   cfg_reg.step_a_x <= cfg_data[rdg_pkg::DELTA_BITS-1:0];
                rdg_pkg::REG_STEP_A_Y:   cfg_reg.step_a_y <= cfg_data[rdg_pkg::DELTA_BITS-1:0];
                rdg_pkg::REG_STEP_B_X:   cfg_reg.step_b_x <= cfg_data[rdg_pkg::DELTA_BITS-1:0];
                rdg_pkg::REG_STEP_B_Y:   cfg_reg.step_b_y <= cfg_data[rdg_pkg::DELTA_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_ready) begin
            a_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            a_req_reg <= dec_req;
        end
    end

    always_comb begin
        point_x_next  = point_x_reg;
        point_y_next  = point_y_reg;
        row_x_next    = row_x_reg;
        row_y_next    = row_y_reg;
        left_next     = left_reg;
        bottom_next   = bottom_reg;
        right_next    = right_reg;
        top_next      = top_reg;
        inner_next    = inner_reg;
        outer_next    = outer_reg;
        finished_next = finished_reg;
        last_next     = 1'b0;
        err_next      = 1'b0;
        if (a_req_reg.start) begin
            point_x_next  = '0;
            point_y_next  = '0;
            row_x_next    = '0;
            row_y_next    = '0;
            left_next     = '0;
            bottom_next   = '0;
            right_next    = '0;
            top_next      = '0;
            inner_next    = '0;
            outer_next    = '0;
            finished_next = !a_req_reg.mode_ok;
            err_next      = !a_req_reg.mode_ok;
        end else if (finished_reg || !a_req_reg.mode_ok) begin
            finished_next = 1'b1;
            err_next      = 1'b1;
        end else begin
            if (a_req_reg.two_d && (inner_reg >= a_req_reg.inner_max)) begin
                inner_next   = '0;
                outer_next   = (outer_reg == '1) ? outer_reg : outer_reg + 1'b1;
                row_x_next   = row_x_reg + a_req_reg.outer_dx;
                row_y_next   = row_y_reg + a_req_reg.outer_dy;
                point_x_next = row_x_next;
                point_y_next = row_y_next;
            end else begin
                inner_next   = (inner_reg == '1) ? inner_reg : inner_reg + 1'b1;
                point_x_next = point_x_reg + a_req_reg.inner_dx;
                point_y_next = point_y_reg + a_req_reg.inner_dy;
            end
            if (point_x_next < left_reg)   left_next   = point_x_next;
            if (point_y_next < bottom_reg) bottom_next = point_y_next;
            if (point_x_next > right_reg)  right_next  = point_x_next;
            if (point_y_next > top_reg)    top_next    = point_y_next;
            last_next = (inner_next >= a_req_reg.inner_max)
                     && (!a_req_reg.two_d || (outer_next >= a_req_reg.outer_max));
            if (last_next) begin
                finished_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            point_x_reg  <= '0;
            point_y_reg  <= '0;
            row_x_reg    <= '0;
            row_y_reg    <= '0;
            left_reg     <= '0;
            bottom_reg   <= '0;
            right_reg    <= '0;
            top_reg      <= '0;
            inner_reg    <= '0;
            outer_reg    <= '0;
            finished_reg <= 1'b1;
            last_reg     <= 1'b0;
            err_reg      <= 1'b0;
        end else begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= a_valid_reg;
            end
            if (out_adv) begin
                point_x_reg  <= point_x_next;
                point_y_reg  <= point_y_next;
                row_x_reg    <= row_x_next;
                row_y_reg    <= row_y_next;
                left_reg     <= left_next;
                bottom_reg   <= bottom_next;
                right_reg    <= right_next;
                top_reg      <= top_next;
                inner_reg    <= inner_next;
                outer_reg    <= outer_next;
                finished_reg <= finished_next;
                last_reg     <= last_next;
                err_reg      <= err_next;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_disp_x     = point_x_reg;
    assign m_disp_y     = point_y_reg;
    assign m_box_left   = left_reg;
    assign m_box_bottom = bottom_reg;
    assign m_box_right  = right_reg;
    assign m_box_top    = top_reg;
    assign m_is_last    = last_reg;
    assign m_error_flag = err_reg;

    // The emitted point always lies inside the running box.
    a_point_in_box: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_box_left <= m_disp_x) && (m_disp_x <= m_box_right)
                 && (m_box_bottom <= m_disp_y) && (m_disp_y <= m_box_top))
        else $error("emitted point lies outside the bounding box");

    a_last_not_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_is_last && m_error_flag))
        else $error("a result is flagged both last and in error");

    // A word in the first stage waits while the result is stalled.
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && m_valid && !m_ready |=> a_valid_reg && $stable(a_req_reg))
        else $error("first stage lost its word under a stalled result");

    a_last_finishes: assert property (@(posedge aclk) disable iff (!aresetn)
        out_adv && last_next |=> finished_reg)
        else $error("expansion still active after its last point");

endmodule
`default_nettype wire

[tb/sv/repetition_displacement_generator_core_tb.sv]
// ----------------------------------------------------------------------------
// repetition_displacement_generator_core_tb
// Drives start and step words into the displacement generator and compares
// every result word, field by field, with a point walker kept in step with
// the register writes. A directed table covers the field extremes, every
// mode, the error paths and mode changes in the middle of a walk. Random
// phases follow: fresh register settings, then mostly complete walks with
// random deltas, with some overruns, cut-off walks and stray words. The
// sender runs in bursts and the receiver stalls on changing patterns.
// ----------------------------------------------------------------------------
module repetition_displacement_generator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rdg_pkg::*;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;
    localparam logic [MODE_BITS-1:0] MODE_BAD_LO = 4'd12;
    localparam logic [MODE_BITS-1:0] MODE_BAD_HI = 4'd15;
    localparam int unsigned IDX_MAX = (1 << COUNT_BITS) - 1;
    localparam int unsigned RANDOM_WORDS = 400;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t left;
        coord_t bottom;
        coord_t right;
        coord_t top;
        logic   last;
        logic   err;
    } point_t;

    typedef struct {
        bit                        is_cfg;
        logic [CFG_INDEX_BITS-1:0] reg_idx;
        logic [CFG_DATA_BITS-1:0]  reg_val;
        logic                      req;
        delta_t                    ex;
        delta_t                    ey;
        bit                        typed;
        point_t                    want;
    } plan_row_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_req_type;
    delta_t                    s_elem_x;
    delta_t                    s_elem_y;
    logic                      m_valid;
    logic                      m_ready;
    coord_t                    m_disp_x;
    coord_t                    m_disp_y;
    coord_t                    m_box_left;
    coord_t                    m_box_bottom;
    coord_t                    m_box_right;
    coord_t                    m_box_top;
    logic                      m_is_last;
    logic                      m_error_flag;

    logic   use_typed;
    point_t typed_point;

    logic [MODE_BITS-1:0] reg_mode;
    count_t               reg_count_a;
    count_t               reg_count_b;
    logic [GRID_BITS-1:0] reg_grid;
    delta_t               reg_step_ax;
    delta_t               reg_step_ay;
    delta_t               reg_step_bx;
    delta_t               reg_step_by;

    coord_t      walk_x, walk_y, row_x, row_y;
    coord_t      box_l, box_b, box_r, box_t;
    int unsigned idx_in, idx_out;
    logic        walk_done;

    point_t      expected_points[$];
    plan_row_t   plan[$];
    int unsigned mismatches;
    int unsigned words_sent;
    int unsigned burst_left;
    bit          steady;

    repetition_displacement_generator_core i_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(string msg);
        $display("%0t ERROR: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [COORD_BITS-1:0] got,
                               logic [COORD_BITS-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task automatic compare_point(point_t got, point_t want);
        check_field("disp_x", got.x, want.x);
        check_field("disp_y", got.y, want.y);
        check_field("box_left", got.left, want.left);
        check_field("box_bottom", got.bottom, want.bottom);
        check_field("box_right", got.right, want.right);
        check_field("box_top", got.top, want.top);
        check_field("is_last", COORD_BITS'(got.last), COORD_BITS'(want.last));
        check_field("error_flag", COORD_BITS'(got.err), COORD_BITS'(want.err));
    endtask

    function automatic void clear_walk();
        walk_x = '0;
        walk_y = '0;
        row_x = '0;
        row_y = '0;
        idx_in = 0;
        idx_out = 0;
        box_l = '0;
        box_b = '0;
        box_r = '0;
        box_t = '0;
    endfunction

    function automatic void reset_walker();
        reg_mode = MODE_REG_2D;
        reg_count_a = '0;
        reg_count_b = '0;
        reg_grid = GRID_BITS'(1);
        reg_step_ax = '0;
        reg_step_ay = '0;
        reg_step_bx = '0;
        reg_step_by = '0;
        clear_walk();
        walk_done = 1'b1;
    endfunction

    function automatic void apply_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] v);
        case (idx)
            REG_REP_MODE:   reg_mode = v[MODE_BITS-1:0];
            REG_COUNT_A:    reg_count_a = v[COUNT_BITS-1:0];
            REG_COUNT_B:    reg_count_b = v[COUNT_BITS-1:0];
            REG_GRID_SCALE: reg_grid = v[GRID_BITS-1:0];
            REG_STEP_A_X:   reg_step_ax = v;
            REG_STEP_A_Y:   reg_step_ay = v;
            REG_STEP_B_X:   reg_step_bx = v;
            REG_STEP_B_Y:   reg_step_by = v;
            default: ;
        endcase
    endfunction

    function automatic int unsigned dim_of(count_t c);
        return int'(c > COUNT_TOP ? COUNT_TOP : c) + 1;
    endfunction

    function automatic point_t snapshot(logic last, logic err);
        return '{walk_x, walk_y, box_l, box_b, box_r, box_t, last, err};
    endfunction

    function automatic point_t next_point(logic req, delta_t ex, delta_t ey);
        logic        mode_ok, two_d, done_now;
        int unsigned na, nb, in_max, out_max;
        coord_t      ix, iy, ox, oy, scaled_x, scaled_y;
        mode_ok = (reg_mode >= MODE_REG_2D) && (reg_mode <= MODE_ARB_GRID);
        two_d = (reg_mode == MODE_REG_2D) || (reg_mode == MODE_DIAG_2D);
        na = dim_of(reg_count_a);
        nb = dim_of(reg_count_b);
        in_max = na;
        out_max = 0;
        ix = '0;
        iy = '0;
        ox = '0;
        oy = '0;
        scaled_x = coord_t'(ex) * coord_t'(reg_grid);
        scaled_y = coord_t'(ey) * coord_t'(reg_grid);
        if (req == REQ_START) begin
            clear_walk();
            walk_done = !mode_ok;
            return snapshot(1'b0, !mode_ok);
        end
        if (walk_done || !mode_ok) begin
            walk_done = 1'b1;
            return snapshot(1'b0, 1'b1);
        end
        case (reg_mode)
            MODE_REG_2D: begin
                out_max = nb;
                ix = coord_t'(reg_step_ax);
                oy = coord_t'(reg_step_by);
            end
            MODE_HREG: ix = coord_t'(reg_step_ax);
            MODE_VREG: begin
                in_max = nb;
                iy = coord_t'(reg_step_ay);
            end
            MODE_HIRR: ix = coord_t'(ex);
            MODE_HIRR_GRID: ix = scaled_x;
            MODE_VIRR: begin
                in_max = nb;
                iy = coord_t'(ex);
            end
            MODE_VIRR_GRID: begin
                in_max = nb;
                iy = scaled_x;
            end
            MODE_DIAG_2D: begin
                in_max = nb;
                out_max = na;
                ix = coord_t'(reg_step_bx);
                iy = coord_t'(reg_step_by);
                ox = coord_t'(reg_step_ax);
                oy = coord_t'(reg_step_ay);
            end
            MODE_DIAG_1D: begin
                ix = coord_t'(reg_step_ax);
                iy = coord_t'(reg_step_ay);
            end
            MODE_ARB: begin
                ix = coord_t'(ex);
                iy = coord_t'(ey);
            end
            default: begin
                ix = scaled_x;
                iy = scaled_y;
            end
        endcase
        if (two_d && idx_in >= in_max) begin
            idx_in = 0;
            if (idx_out < IDX_MAX)
                idx_out++;
            row_x += ox;
            row_y += oy;
            walk_x = row_x;
            walk_y = row_y;
        end else begin
            if (idx_in < IDX_MAX)
                idx_in++;
            walk_x += ix;
            walk_y += iy;
        end
        if (walk_x < box_l) box_l = walk_x;
        if (walk_y < box_b) box_b = walk_y;
        if (walk_x > box_r) box_r = walk_x;
        if (walk_y > box_t) box_t = walk_y;
        done_now = (idx_in >= in_max) && (!two_d || idx_out >= out_max);
        if (done_now)
            walk_done = 1'b1;
        return snapshot(done_now, 1'b0);
    endfunction

    always @(posedge aclk) begin : monitor
        point_t got;
        point_t want;
        if (!aresetn) begin
            reset_walker();
        end else begin
            if (m_valid && m_ready) begin
                got = {m_disp_x, m_disp_y, m_box_left, m_box_bottom, m_box_right,
                       m_box_top, m_is_last, m_error_flag};
                if (expected_points.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = expected_points.pop_front();
                    compare_point(got, want);
                end
            end
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                want = next_point(s_req_type, s_elem_x, s_elem_y);
                if (use_typed)
                    want = typed_point;
                expected_points = {expected_points, want};
            end
        end
    end

    initial begin
        int unsigned kind, span;
        m_ready = 1'b0;
        forever begin
            kind = $urandom_range(0, 3);
            span = $urandom_range(10, 60);
            repeat (span) begin
                @(negedge aclk);
                case (kind)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 7) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic point_t pt(coord_t x, coord_t y, coord_t l, coord_t b, coord_t r,
                                  coord_t t, logic last, logic err);
        return '{x, y, l, b, r, t, last, err};
    endfunction

    function automatic void plan_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                     logic [CFG_DATA_BITS-1:0] v);
        plan_row_t r;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = v;
        r.req = REQ_START;
        r.ex = '0;
        r.ey = '0;
        r.typed = 1'b0;
        r.want = '0;
        plan = {plan, r};
    endfunction

    function automatic void plan_word(logic req, delta_t ex, delta_t ey, bit typed,
                                      point_t want);
        plan_row_t r;
        r.is_cfg = 1'b0;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.req = req;
        r.ex = ex;
        r.ey = ey;
        r.typed = typed;
        r.want = want;
        plan = {plan, r};
    endfunction

    function automatic delta_t rand_delta();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return delta_t'(int'($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    function automatic count_t rand_count();
        case ($urandom_range(0, 11))
            0: return COUNT_TOP;
            1: return {COUNT_BITS{1'b1}};
            2: return count_t'($urandom);
            default: return count_t'($urandom_range(0, 4));
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] rand_reg_value(
            logic [CFG_INDEX_BITS-1:0] idx);
        logic [CFG_DATA_BITS-1:0] v;
        v = ($urandom_range(0, 1) != 0) ? $urandom : '0;
        case (idx)
            REG_REP_MODE: begin
                if ($urandom_range(0, 7) != 0)
                    v[MODE_BITS-1:0] = 4'($urandom_range(MODE_REG_2D, MODE_ARB_GRID));
                else if ($urandom_range(0, 4) == 0)
                    v[MODE_BITS-1:0] = MODE_REUSE;
                else
                    v[MODE_BITS-1:0] = 4'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
            end
            REG_COUNT_A, REG_COUNT_B: v[COUNT_BITS-1:0] = rand_count();
            REG_GRID_SCALE: begin
                case ($urandom_range(0, 5))
                    0: v[GRID_BITS-1:0] = '0;
                    1: v[GRID_BITS-1:0] = '1;
                    2: v[GRID_BITS-1:0] = GRID_BITS'(1);
                    default: v[GRID_BITS-1:0] = GRID_BITS'($urandom);
                endcase
            end
            default: v = rand_delta();
        endcase
        return v;
    endfunction

    function automatic int unsigned steps_to_end();
        int unsigned na, nb;
        na = dim_of(reg_count_a);
        nb = dim_of(reg_count_b);
        case (reg_mode)
            MODE_REG_2D, MODE_DIAG_2D: return (na + 1) * (nb + 1) - 1;
            MODE_VREG, MODE_VIRR, MODE_VIRR_GRID: return nb;
            MODE_HREG, MODE_HIRR, MODE_HIRR_GRID, MODE_DIAG_1D, MODE_ARB,
            MODE_ARB_GRID: return na;
            default: return 1;
        endcase
    endfunction

    task automatic send_word(logic req, delta_t ex, delta_t ey, bit typed, point_t want);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_req_type <= req;
        s_elem_x <= ex;
        s_elem_y <= ey;
        use_typed <= typed;
        typed_point <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_paced(logic req, delta_t ex, delta_t ey);
        if (!steady) begin
            if (burst_left == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    @(negedge aclk);
                    s_valid <= 1'b0;
                end
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        send_word(req, ex, ey, 1'b0, '0);
        words_sent++;
    endtask

    task automatic drain();
        do begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end while (expected_points.size() != 0);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic cfg_idle();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned n_seq, seq, n_steps;
        logic [CFG_INDEX_BITS-1:0] idx;
        bit first;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_req_type = REQ_START;
        s_elem_x = '0;
        s_elem_y = '0;
        use_typed = 1'b0;
        typed_point = '0;
        mismatches = 0;
        words_sent = 0;
        burst_left = 0;
        steady = 1'b1;

        plan_word(REQ_STEP, '0, '0, 1'b1, pt('0, '0, '0, '0, '0, '0, 1'b0, 1'b1));
        plan_word(REQ_START, '1, '1, 1'b1, pt('0, '0, '0, '0, '0, '0, 1'b0, 1'b0));
        plan_reg(REG_REP_MODE, MODE_REUSE);
        plan_word(REQ_START, '0, '0, 1'b1, pt('0, '0, '0, '0, '0, '0, 1'b0, 1'b1));
        plan_reg(REG_REP_MODE, MODE_HREG);
        plan_reg(REG_STEP_A_X, 32'h7FFF_FFFF);
        plan_word(REQ_START, '0, '0, 1'b0, '0);
        plan_word(REQ_STEP, '0, '0, 1'b1,
                  pt(48'h7FFF_FFFF, '0, '0, '0, 48'h7FFF_FFFF, '0, 1'b1, 1'b0));
        plan_word(REQ_STEP, '0, '0, 1'b1,
                  pt(48'h7FFF_FFFF, '0, '0, '0, 48'h7FFF_FFFF, '0, 1'b0, 1'b1));
        plan_reg(REG_REP_MODE, MODE_REG_2D);
        plan_reg(REG_STEP_A_X, 32'h8000_0000);
        plan_reg(REG_STEP_B_Y, 32'h7FFF_FFFF);
        plan_word(REQ_START, '0, '0, 1'b0, '0);
        repeat (3) plan_word(REQ_STEP, '0, '0, 1'b0, '0);
        plan_reg(REG_REP_MODE, MODE_DIAG_2D);
        plan_reg(REG_STEP_A_Y, 32'h8000_0000);
        plan_reg(REG_STEP_B_X, 32'h7FFF_FFFF);
        plan_word(REQ_START, '0, '0, 1'b0, '0);
        repeat (3) plan_word(REQ_STEP, '0, '0, 1'b0, '0);
        plan_reg(REG_GRID_SCALE, 32'h0000_FFFF);
        plan_reg(REG_COUNT_A, 32'h0000_FFFF);
        plan_reg(REG_REP_MODE, MODE_ARB_GRID);
        plan_word(REQ_START, '0, '0, 1'b0, '0);
        plan_word(REQ_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0);
        plan_reg(REG_REP_MODE, MODE_ARB);
        plan_word(REQ_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0);
        plan_reg(REG_REP_MODE, MODE_HIRR_GRID);
        plan_word(REQ_STEP, 32'hFFFF_FFFF, '0, 1'b0, '0);
        plan_reg(REG_REP_MODE, MODE_HIRR);
        plan_word(REQ_STEP, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, '0);
        plan_reg(REG_REP_MODE, MODE_VIRR);
        plan_word(REQ_STEP, 32'h7FFF_FFFF, '0, 1'b0, '0);
        plan_reg(REG_REP_MODE, MODE_VIRR_GRID);
        plan_reg(REG_COUNT_B, 32'h0000_0001);
        plan_reg(REG_GRID_SCALE, '0);
        plan_word(REQ_START, '0, '0, 1'b0, '0);
        plan_word(REQ_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0);
        plan_reg(REG_REP_MODE, MODE_VREG);
        plan_word(REQ_STEP, '0, '0, 1'b0, '0);
        plan_reg(REG_REP_MODE, MODE_DIAG_1D);
        plan_reg(REG_COUNT_A, 32'h0000_0001);
        plan_word(REQ_START, '0, '0, 1'b0, '0);
        plan_word(REQ_STEP, '0, '0, 1'b0, '0);
        plan_reg(REG_REP_MODE, MODE_BAD_LO);
        plan_word(REQ_STEP, '0, '0, 1'b0, '0);
        plan_word(REQ_START, '0, '0, 1'b1, pt('0, '0, '0, '0, '0, '0, 1'b0, 1'b1));

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
                cfg_idle();
            end else begin
                send_word(plan[i].req, plan[i].ex, plan[i].ey, plan[i].typed, plan[i].want);
            end
        end

        first = 1'b1;
        while (words_sent < RANDOM_WORDS) begin
            drain();
            if (first || $urandom_range(0, 4) == 0) begin
                for (int r = 0; r <= REG_STEP_B_Y; r++)
                    write_reg(CFG_INDEX_BITS'(r), rand_reg_value(CFG_INDEX_BITS'(r)));
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    idx = CFG_INDEX_BITS'($urandom_range(REG_REP_MODE, REG_STEP_B_Y));
                    write_reg(idx, rand_reg_value(idx));
                end
            end
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_INDEX_BITS'($urandom_range(REG_STEP_B_Y + 1,
                          (1 << CFG_INDEX_BITS) - 1)), $urandom);
            cfg_idle();
            first = 1'b0;
            steady = ($urandom_range(0, 3) == 0);
            n_seq = $urandom_range(1, 4);
            for (seq = 0; seq < n_seq; seq++) begin
                if (seq != 0 || $urandom_range(0, 3) != 0)
                    send_paced(REQ_START, rand_delta(), rand_delta());
                n_steps = steps_to_end();
                if (n_steps > 40)
                    n_steps = $urandom_range(3, 12);
                case ($urandom_range(0, 7))
                    0: n_steps = n_steps + $urandom_range(1, 2);
                    1: n_steps = $urandom_range(0, n_steps);
                    default: ;
                endcase
                repeat (n_steps)
                    send_paced(REQ_STEP, rand_delta(), rand_delta());
                if ($urandom_range(0, 9) == 0)
                    send_paced(1'($urandom_range(0, 1)), $urandom, $urandom);
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (expected_points.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived",
                                      expected_points.size()));
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
